// File: design/rdir_pkg.sv
// Shared constants, types and trig tables for the IR ring direction estimator.
package rdir_pkg;

  localparam int SENSORS   = 24;
  localparam int TRIG_BITS = 16;
  localparam int HALF_RING = SENSORS / 2;
  localparam int IDX_W     = $clog2(SENSORS);
  localparam int RAW_W     = 10;
  localparam int VAL_W     = 11;
  localparam int FS_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int OUT_W     = 16;
  localparam int HD_W      = $clog2(HALF_RING + 1);
  localparam int PROD_W    = VAL_W + HD_W;
  // reciprocal of HALF_RING for the weight division
  localparam int RECIP_SH  = 32;
  localparam int RECIP_W   = 33;
  localparam longint RECIP = ((64'sd1 <<< RECIP_SH) + HALF_RING - 1) / HALF_RING;
  localparam int ACC_W     = VAL_W + $clog2(SENSORS) + TRIG_BITS;
  localparam int GUARD     = 16;
  localparam int CW        = ACC_W + GUARD + 2;
  localparam int ZW        = 36;
  localparam int ITER      = 30;
  localparam int K_W       = 5;
  localparam int M_W       = ACC_W + 2;
  localparam int DEN_W     = FS_W + TRIG_BITS - 1;
  localparam int REM_W     = (M_W > DEN_W ? M_W : DEN_W) + 1;
  localparam int QBITS     = 15;
  localparam int Q_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FSCALE = 2'd1;

  localparam logic [VAL_W-1:0] OFFSET_RST = 11'd1050;
  localparam logic [FS_W-1:0]  FSCALE_RST = 16'd3600;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint GAIN_Q16    = 64'sd39797;
  localparam longint ANGLE_MAX   = 64'sd25736;

  typedef longint atan_arr_t [ITER];
  localparam atan_arr_t ATAN_Q30 = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2};

  typedef logic signed [TRIG_BITS-1:0] trig_arr_t [SENSORS];

  // frame token handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0] strongest;
  } frame_tok_t;

  // round Q2.30 to Q1.(TRIG_BITS-1) and clamp
  function automatic longint to_trig(input longint q30);
    longint lim;
    longint r;
    lim = (64'sd1 <<< (TRIG_BITS - 1)) - 1;
    r = (q30 + (64'sd1 <<< (30 - TRIG_BITS))) >>> (31 - TRIG_BITS);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // cosine (sel 0) or sine (sel 1) of each sensor angle via rotation CORDIC
  function automatic trig_arr_t build_trig(input bit sel);
    trig_arr_t t;
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit neg;
    for (int i = 0; i < SENSORS; i++) begin
      z = longint'(i) * TWO_PI_Q30 / SENSORS;
      neg = 1'b0;
      if (z > PI_Q30) z = z - TWO_PI_Q30;
      if (z > HALF_PI_Q30) begin
        z = z - PI_Q30;
        neg = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
        z = z + PI_Q30;
        neg = 1'b1;
      end
      x = GAIN_Q30;
      y = 0;
      for (int k = 0; k < ITER; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_Q30[k];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_Q30[k];
        end
      end
      if (neg) begin
        x = -x;
        y = -y;
      end
      t[i] = sel ? TRIG_BITS'(to_trig(y)) : TRIG_BITS'(to_trig(x));
    end
    return t;
  endfunction

  localparam trig_arr_t COS_ROM = build_trig(1'b0);
  localparam trig_arr_t SIN_ROM = build_trig(1'b1);

endpackage

// File: design/rdir_front.sv
// Front end: converts readings to strength, stores the frame, tracks the peak.
module rdir_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [rdir_pkg::RAW_W-1:0]        raw_reading,
  input  logic [rdir_pkg::VAL_W-1:0]        sample_offset,
  input  logic [rdir_pkg::IDX_W-1:0]        rd_addr,
  output logic [rdir_pkg::VAL_W-1:0]        rd_data,
  output logic                              push,
  output rdir_pkg::frame_tok_t              push_tok
);

  logic [rdir_pkg::VAL_W-1:0] store_r [rdir_pkg::SENSORS];
  logic [rdir_pkg::VAL_W-1:0] rd_data_r;
  logic [rdir_pkg::IDX_W-1:0] count_r;
  logic [rdir_pkg::IDX_W-1:0] best_idx_r;
  logic [rdir_pkg::VAL_W-1:0] best_val_r;
  logic [rdir_pkg::VAL_W-1:0] val;
  logic                       take;
  logic                       last;
  logic [rdir_pkg::VAL_W-1:0] raw_ext;

  assign raw_ext = rdir_pkg::VAL_W'(raw_reading);
  assign val     = (sample_offset > raw_ext) ? (sample_offset - raw_ext) : '0;
  assign take    = (count_r == '0) || (val > best_val_r);
  assign last    = (count_r == rdir_pkg::IDX_W'(rdir_pkg::SENSORS - 1));

  // frame storage with registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      store_r[count_r] <= val;
    end
    rd_data_r <= store_r[rd_addr];
  end

  // sample position and peak tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      best_idx_r <= '0;
      best_val_r <= '0;
    end else if (accept) begin
      if (last) begin
        count_r    <= '0;
        best_idx_r <= '0;
        best_val_r <= '0;
      end else begin
        count_r <= count_r + 1'b1;
        if (take) begin
          best_idx_r <= count_r;
          best_val_r <= val;
        end
      end
    end
  end

  assign rd_data            = rd_data_r;
  assign push               = accept && last;
  assign push_tok.strongest = take ? count_r : best_idx_r;

endmodule

// File: design/rdir_queue.sv
// Two-entry queue of completed frame tokens between front and back.
module rdir_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rdir_pkg::frame_tok_t push_tok,
  input  logic                 pop,
  output logic                 not_empty,
  output rdir_pkg::frame_tok_t head
);

  rdir_pkg::frame_tok_t slot_r [2];
  logic                 rd_ptr_r;
  logic                 wr_ptr_r;
  logic [1:0]           count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

endmodule

// File: design/rdir_back.sv
// Back end: weighted vector sum, vectoring CORDIC and strength division.
module rdir_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              tok_valid,
  input  rdir_pkg::frame_tok_t              tok,
  output logic                              tok_pop,
  input  logic [rdir_pkg::FS_W-1:0]         full_scale,
  output logic [rdir_pkg::IDX_W-1:0]        rd_addr,
  input  logic [rdir_pkg::VAL_W-1:0]        rd_data,
  output logic                              active,
  output logic                              out_valid,
  output logic signed [rdir_pkg::OUT_W-1:0] out_angle,
  output logic [rdir_pkg::OUT_W-1:0]        out_strength
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_DIV, S_TRIG, S_ADD,
    S_CSTART, S_CITER, S_MAG, S_DCHK, S_DSTEP, S_OUT
  } state_t;

  state_t state_r;
  logic [rdir_pkg::IDX_W-1:0]            idx_r;
  logic [rdir_pkg::IDX_W-1:0]            peak_r;
  logic [rdir_pkg::PROD_W-1:0]           p_r;
  logic [rdir_pkg::VAL_W-1:0]            w_r;
  logic signed [rdir_pkg::ACC_W-1:0]     px_r;
  logic signed [rdir_pkg::ACC_W-1:0]     py_r;
  logic signed [rdir_pkg::ACC_W-1:0]     ax_r;
  logic signed [rdir_pkg::ACC_W-1:0]     ay_r;
  logic signed [rdir_pkg::CW-1:0]        cx_r;
  logic signed [rdir_pkg::CW-1:0]        cy_r;
  logic signed [rdir_pkg::ZW-1:0]        z_r;
  logic [rdir_pkg::K_W-1:0]              k_r;
  logic [rdir_pkg::REM_W-1:0]            r_r;
  logic [rdir_pkg::REM_W-1:0]            den_r;
  logic [rdir_pkg::Q_W-1:0]              q_r;
  logic signed [rdir_pkg::OUT_W-1:0]     angle_r;
  logic                                  out_valid_r;
  logic signed [rdir_pkg::OUT_W-1:0]     out_angle_r;
  logic [rdir_pkg::OUT_W-1:0]            out_strength_r;

  // circular distance and weight factor
  logic [rdir_pkg::IDX_W-1:0] diff;
  logic [rdir_pkg::IDX_W:0]   ring_dist;
  logic [rdir_pkg::HD_W-1:0]  hd;
  assign diff = (idx_r > peak_r) ? (idx_r - peak_r) : (peak_r - idx_r);
  assign ring_dist = ((rdir_pkg::IDX_W+1)'(diff) > (rdir_pkg::IDX_W+1)'(rdir_pkg::HALF_RING))
                   ? (rdir_pkg::IDX_W+1)'(rdir_pkg::SENSORS) - (rdir_pkg::IDX_W+1)'(diff)
                   : (rdir_pkg::IDX_W+1)'(diff);
  assign hd   = rdir_pkg::HD_W'((rdir_pkg::IDX_W+1)'(rdir_pkg::HALF_RING) - ring_dist);

  // division by the half ring through a reciprocal
  logic [rdir_pkg::PROD_W+rdir_pkg::RECIP_W-1:0] recip_prod;
  assign recip_prod = (rdir_pkg::PROD_W+rdir_pkg::RECIP_W)'(p_r)
                    * (rdir_pkg::PROD_W+rdir_pkg::RECIP_W)'(rdir_pkg::RECIP);

  // CORDIC step
  logic signed [rdir_pkg::CW-1:0] sh_x;
  logic signed [rdir_pkg::CW-1:0] sh_y;
  logic signed [rdir_pkg::ZW-1:0] atan_k;
  assign sh_x   = cx_r >>> k_r;
  assign sh_y   = cy_r >>> k_r;
  assign atan_k = rdir_pkg::ZW'(rdir_pkg::ATAN_Q30[k_r]);

  // CORDIC start values
  logic signed [rdir_pkg::CW-1:0] gx;
  logic signed [rdir_pkg::CW-1:0] gy;
  assign gx = rdir_pkg::CW'(ax_r) <<< rdir_pkg::GUARD;
  assign gy = rdir_pkg::CW'(ay_r) <<< rdir_pkg::GUARD;

  // angle rounding; the clamp is applied in S_MAG
  logic signed [rdir_pkg::ZW-1:0] z_rnd;
  assign z_rnd = (z_r + (rdir_pkg::ZW'(1) <<< 16)) >>> 17;

  // magnitude rescale
  logic [rdir_pkg::M_W-1:0]    mag;
  logic [rdir_pkg::M_W+16:0]   mag_gain;
  logic [rdir_pkg::FS_W-1:0]   fs_eff;
  logic [rdir_pkg::REM_W-1:0]  rem_sh;
  assign mag      = (cx_r > 0) ? rdir_pkg::M_W'(cx_r >>> rdir_pkg::GUARD) : '0;
  assign mag_gain = (rdir_pkg::M_W+17)'(mag) * (rdir_pkg::M_W+17)'(rdir_pkg::GAIN_Q16);
  assign fs_eff   = (full_scale == '0) ? rdir_pkg::FS_W'(1) : full_scale;
  assign rem_sh   = r_r << 1;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_OUT);
      unique case (state_r)
        S_IDLE: begin
          if (tok_valid) begin
            peak_r  <= tok.strongest;
            idx_r   <= '0;
            ax_r    <= '0;
            ay_r    <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_MUL;
        S_MUL: begin
          p_r     <= rdir_pkg::PROD_W'(rd_data) * rdir_pkg::PROD_W'(hd);
          state_r <= S_DIV;
        end
        S_DIV: begin
          w_r     <= rdir_pkg::VAL_W'(recip_prod >> rdir_pkg::RECIP_SH);
          state_r <= S_TRIG;
        end
        S_TRIG: begin
          px_r <= rdir_pkg::ACC_W'(rdir_pkg::COS_ROM[idx_r])
                * $signed({{(rdir_pkg::ACC_W-rdir_pkg::VAL_W){1'b0}}, w_r});
          py_r <= rdir_pkg::ACC_W'(rdir_pkg::SIN_ROM[idx_r])
                * $signed({{(rdir_pkg::ACC_W-rdir_pkg::VAL_W){1'b0}}, w_r});
          state_r <= S_ADD;
        end
        S_ADD: begin
          ax_r <= ax_r + px_r;
          ay_r <= ay_r + py_r;
          if (idx_r == rdir_pkg::IDX_W'(rdir_pkg::SENSORS - 1)) begin
            state_r <= S_CSTART;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_CSTART: begin
          k_r <= '0;
          if (ax_r == '0 && ay_r == '0) begin
            angle_r <= '0;
            q_r     <= '0;
            state_r <= S_OUT;
          end else begin
            if (ax_r < 0) begin
              cx_r <= -gx;
              cy_r <= -gy;
              z_r  <= (ay_r >= 0) ? rdir_pkg::ZW'(rdir_pkg::PI_Q30)
                                  : -rdir_pkg::ZW'(rdir_pkg::PI_Q30);
            end else begin
              cx_r <= gx;
              cy_r <= gy;
              z_r  <= '0;
            end
            state_r <= S_CITER;
          end
        end
        S_CITER: begin
          if (cy_r > 0) begin
            cx_r <= cx_r + sh_y;
            cy_r <= cy_r - sh_x;
            z_r  <= z_r + atan_k;
          end else begin
            cx_r <= cx_r - sh_y;
            cy_r <= cy_r + sh_x;
            z_r  <= z_r - atan_k;
          end
          k_r <= k_r + 1'b1;
          if (k_r == rdir_pkg::K_W'(rdir_pkg::ITER - 1)) state_r <= S_MAG;
        end
        S_MAG: begin
          if (z_rnd > rdir_pkg::ZW'(rdir_pkg::ANGLE_MAX)) begin
            angle_r <= rdir_pkg::OUT_W'(rdir_pkg::ANGLE_MAX);
          end else if (z_rnd < -rdir_pkg::ZW'(rdir_pkg::ANGLE_MAX)) begin
            angle_r <= -rdir_pkg::OUT_W'(rdir_pkg::ANGLE_MAX);
          end else begin
            angle_r <= rdir_pkg::OUT_W'(z_rnd);
          end
          r_r     <= rdir_pkg::REM_W'(mag_gain >> 16);
          den_r   <= rdir_pkg::REM_W'(fs_eff) << (rdir_pkg::TRIG_BITS - 1);
          state_r <= S_DCHK;
        end
        S_DCHK: begin
          k_r <= '0;
          if (r_r >= den_r) begin
            q_r     <= rdir_pkg::Q_W'(1) << rdir_pkg::QBITS;
            state_r <= S_OUT;
          end else begin
            q_r     <= '0;
            state_r <= S_DSTEP;
          end
        end
        S_DSTEP: begin
          // restoring division, one quotient bit per cycle
          if (rem_sh >= den_r) begin
            r_r <= rem_sh - den_r;
            q_r <= {q_r[rdir_pkg::Q_W-2:0], 1'b1};
          end else begin
            r_r <= rem_sh;
            q_r <= {q_r[rdir_pkg::Q_W-2:0], 1'b0};
          end
          k_r <= k_r + 1'b1;
          if (k_r == rdir_pkg::K_W'(rdir_pkg::QBITS - 1)) state_r <= S_OUT;
        end
        S_OUT: begin
          out_angle_r    <= angle_r;
          out_strength_r <= q_r;
          state_r        <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign tok_pop      = (state_r == S_IDLE) && tok_valid;
  assign rd_addr      = idx_r;
  assign active       = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_angle    = out_angle_r;
  assign out_strength = out_strength_r;

endmodule

// File: design/ir_ring_direction_estimator.sv
// Top level: IR ring direction estimator with configuration registers.
// One reading per cycle is taken while busy is low and a frame fills; after
// the last reading the back end weights and sums each sensor and, if the sum is
// nonzero, does 30 CORDIC and up to 15 division steps, then a one-cycle result.
// Throughput: busy stays high from the end of a frame until its result is out.
// Reset: sync active-low; clears frame position, peak, queue and sequencer.
module ir_ring_direction_estimator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rdir_pkg::RAW_W-1:0]        in_raw_reading,
  output logic                              out_valid,
  output logic signed [rdir_pkg::OUT_W-1:0] out_direction_angle,
  output logic [rdir_pkg::OUT_W-1:0]        out_strength,
  input  logic                              cfg_we,
  input  logic [rdir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rdir_pkg::CFG_W-1:0]        cfg_data
);

  logic [rdir_pkg::VAL_W-1:0] offset_r;
  logic [rdir_pkg::FS_W-1:0]  fscale_r;
  logic                       accept;
  logic [rdir_pkg::IDX_W-1:0] rd_addr;
  logic [rdir_pkg::VAL_W-1:0] rd_data;
  logic                       push;
  rdir_pkg::frame_tok_t       push_tok;
  logic                       q_ne;
  rdir_pkg::frame_tok_t       q_head;
  logic                       pop;
  logic                       back_active;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= rdir_pkg::OFFSET_RST;
      fscale_r <= rdir_pkg::FSCALE_RST;
    end else if (cfg_we) begin
      if (cfg_index == rdir_pkg::REG_OFFSET) offset_r <= cfg_data[rdir_pkg::VAL_W-1:0];
      else if (cfg_index == rdir_pkg::REG_FSCALE) fscale_r <= cfg_data[rdir_pkg::FS_W-1:0];
    end
  end

  assign busy   = q_ne || back_active;
  assign accept = start && !busy;

  rdir_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .raw_reading   (in_raw_reading),
    .sample_offset (offset_r),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .push          (push),
    .push_tok      (push_tok)
  );

  rdir_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tok  (push_tok),
    .pop       (pop),
    .not_empty (q_ne),
    .head      (q_head)
  );

  rdir_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .tok_valid    (q_ne),
    .tok          (q_head),
    .tok_pop      (pop),
    .full_scale   (fscale_r),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .active       (back_active),
    .out_valid    (out_valid),
    .out_angle    (out_direction_angle),
    .out_strength (out_strength)
  );

  // result strobe lasts a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // strength never exceeds 1.0
  a_strength_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_strength <= 16'd32768)) else $error("strength out of range");

  // a frame end is never accepted while the back end is still working
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !back_active) else $error("frame finished during back-end work");

endmodule
